### hdl/assert_macros.svh
// Assertion macros for the checker file of the project.
// Clocked on a rising edge, disabled while the active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dcd_pkg.sv
// Shared types and constants for the directed cycle detector.
// Used by the controller, the datapath, the top level and the checker.
package dcd_pkg;

  localparam int MAX_NODES  = 64;
  localparam int VIDX_W     = $clog2(MAX_NODES);
  localparam int CUR_W      = $clog2(MAX_NODES + 1);
  localparam int VERT_W     = 7;
  localparam int NODE_W     = 7;
  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_FIND,
    ST_POP,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_graph;
    logic add_read;
    logic add_write;
    logic load_start;
    logic find;
    logic pop_load;
    logic result_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic start_ok;
    logic add_ok;
    logic hit;
    logic hit_gray;
    logic depth_one;
    logic out_free;
  } status_t;

  // One level of the walk: vertex index and next column to scan
  typedef struct packed {
    logic [VIDX_W-1:0] vidx;
    logic [CUR_W-1:0]  cur;
  } stack_entry_t;

endpackage

### hdl/directed_cycle_detect.sv
// Directed cycle detector: a 64-vertex adjacency bit matrix with a
// depth-first cycle check. Top level; joins dcd_ctrl and dcd_datapath.
//
// Input beats carry the mode in tuser and the two vertices in tdata.
// Clear is done as the beat is taken and gives no result. Add edge reads
// the row, then writes it back, and gives no result. Check gives one result beat
// with the flag in bit 0 of m_axis_tdata.
// A check walks the graph depth first until its result is registered:
// it pushes vertices (the new row is read as each is pushed), pops back
// to a parent (one stack read, then one adjacency row read), and skips
// edges to finished vertices. A start vertex out of range goes straight
// to the result. The adjacency memory has a single read port.
// s_axis_tready is high only while no beat is in work. A finished result
// sits in the output register; the next beat is taken while it waits, and
// a later check holds in its last step until that register is free.
// Reset empties the graph, sets the vertex count to one and drops any
// pending result. The vertex count is written through cfg_we_i.
module directed_cycle_detect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcd_pkg::NODE_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: from_vertex [6:0], to_vertex [13:7], zero [15:14]
  input  logic [dcd_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: mode [1:0]
  input  logic [dcd_pkg::MODE_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: has_cycle [0], zero [7:1]
  output logic [dcd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import dcd_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic              out_flag;
  logic [VERT_W-1:0] in_from, in_to;

  // Unpack the input beat
  assign in_from = s_axis_tdata[VERT_W-1:0];
  assign in_to   = s_axis_tdata[2*VERT_W-1:VERT_W];

  dcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dcd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_from_i   (in_from),
    .in_to_i     (in_to),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_flag_o  (out_flag)
  );

  // Pack the result beat
  assign m_axis_tdata = OUT_DATA_W'(out_flag);

endmodule

### hdl/dcd_ctrl.sv
// Controller state machine of the directed cycle detector.
// Depends on dcd_pkg for the state, command and status types.
module dcd_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [dcd_pkg::MODE_W-1:0] in_mode_i,
  output logic                     in_ready_o,
  input  dcd_pkg::status_t         status_i,
  output dcd_pkg::cmd_t            cmd_o
);
  import dcd_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_mode_i)
            MODE_CLEAR: begin
              cmd_o.clear_graph = 1'b1;
            end
            MODE_ADD: begin
              if (status_i.add_ok) begin
                cmd_o.add_read = 1'b1;
                state_d        = ST_ADD_WR;
              end
            end
            MODE_CHECK: begin
              cmd_o.load_start = 1'b1;
              state_d          = status_i.start_ok ? ST_FIND : ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_WR: begin
        cmd_o.add_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        if (!status_i.hit) begin
          state_d = status_i.depth_one ? ST_DONE : ST_POP;
        end else if (status_i.hit_gray) begin
          state_d = ST_DONE;
        end
      end
      ST_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = ST_FIND;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/dcd_datapath.sv
// Datapath of the directed cycle detector: adjacency memory, path stack,
// vertex marks, next-edge find and the result register. Depends on dcd_pkg.
module dcd_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dcd_pkg::NODE_W-1:0] cfg_wdata_i,
  input  logic [dcd_pkg::VERT_W-1:0] in_from_i,
  input  logic [dcd_pkg::VERT_W-1:0] in_to_i,
  input  dcd_pkg::cmd_t              cmd_i,
  output dcd_pkg::status_t           status_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       out_flag_o
);
  import dcd_pkg::*;

  logic [NODE_W-1:0]    node_count_q;
  logic [CUR_W-1:0]     n_eff;
  logic [VERT_W-1:0]    from_m1, to_m1;
  logic [VIDX_W-1:0]    from_idx, to_idx;
  logic                 start_ok, add_ok;

  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] adj_rd_q;
  logic                 rd_valid_q;
  logic [MAX_NODES-1:0] row_valid_q;
  logic                 adj_re;
  logic [VIDX_W-1:0]    adj_raddr;
  logic [MAX_NODES-1:0] row;
  logic [VIDX_W-1:0]    add_row_q, add_col_q;

  stack_entry_t         stk_mem [MAX_NODES];
  stack_entry_t         stk_rd_q;
  logic [CUR_W-1:0]     depth_q;
  logic [VIDX_W-1:0]    top_v_q;
  logic [CUR_W-1:0]     top_cur_q;
  logic [VIDX_W-1:0]    push_addr, pop_addr;

  logic [MAX_NODES-1:0] gray_q, black_q;
  logic [MAX_NODES-1:0] lo_mask, hi_mask, cand, low_bit;
  logic [VIDX_W-1:0]    w_idx;
  logic [CUR_W-1:0]     w_next;
  logic                 hit, hit_gray, hit_black, depth_one, push, pop;
  logic                 result_q, out_valid_q, out_flag_q;

  // Node count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_W'(1);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  // Range checks on the incoming beat
  assign n_eff    = (int'(node_count_q) > MAX_NODES) ? CUR_W'(MAX_NODES)
                                                     : CUR_W'(node_count_q);
  assign from_m1  = in_from_i - VERT_W'(1);
  assign to_m1    = in_to_i - VERT_W'(1);
  assign from_idx = VIDX_W'(from_m1);
  assign to_idx   = VIDX_W'(to_m1);
  assign start_ok = (in_from_i != '0) && (int'(in_from_i) <= int'(n_eff));
  assign add_ok   = (in_from_i != '0) && (int'(in_from_i) <= MAX_NODES) &&
                    (in_to_i != '0) && (int'(in_to_i) <= MAX_NODES);

  // Next edge: lowest set column at or above the cursor and below the count
  assign row     = rd_valid_q ? adj_rd_q : '0;
  assign lo_mask = {MAX_NODES{1'b1}} << top_cur_q;
  assign hi_mask = ~({MAX_NODES{1'b1}} << n_eff);
  assign cand    = row & lo_mask & hi_mask;
  assign low_bit = cand & (~cand + MAX_NODES'(1));
  assign hit     = |cand;

  always_comb begin
    w_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (low_bit[i]) begin
        w_idx = w_idx | VIDX_W'(i);
      end
    end
  end

  assign w_next    = CUR_W'(w_idx) + CUR_W'(1);
  assign hit_gray  = gray_q[w_idx];
  assign hit_black = black_q[w_idx];
  assign depth_one = (depth_q == CUR_W'(1));
  assign push      = cmd_i.find && hit && !hit_gray && !hit_black;
  assign pop       = cmd_i.find && !hit && !depth_one;
  assign push_addr = VIDX_W'(depth_q - CUR_W'(1));
  assign pop_addr  = VIDX_W'(depth_q - CUR_W'(2));

  // Adjacency read address
  always_comb begin
    adj_re    = 1'b1;
    adj_raddr = '0;
    if (cmd_i.load_start || cmd_i.add_read) begin
      adj_raddr = from_idx;
    end else if (push) begin
      adj_raddr = w_idx;
    end else if (cmd_i.pop_load) begin
      adj_raddr = stk_rd_q.vidx;
    end else begin
      adj_re = 1'b0;
    end
  end

  // Adjacency memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      adj_mem[add_row_q] <= row | (MAX_NODES'(1) << add_col_q);
    end
    if (adj_re) begin
      adj_rd_q <= adj_mem[adj_raddr];
    end
  end

  // Row valid bits: clear drops every row at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_graph) begin
        row_valid_q <= '0;
      end else if (cmd_i.add_write) begin
        row_valid_q[add_row_q] <= 1'b1;
      end
      if (adj_re) begin
        rd_valid_q <= row_valid_q[adj_raddr];
      end
    end
  end

  // Hold the edge to add
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_read) begin
      add_row_q <= from_idx;
      add_col_q <= to_idx;
    end
  end

  // Path stack memory: push writes the current top, pop reads the one below
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_mem[push_addr] <= '{vidx: top_v_q, cur: w_next};
    end
    if (pop) begin
      stk_rd_q <= stk_mem[pop_addr];
    end
  end

  // Top of the walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      top_v_q   <= from_idx;
      top_cur_q <= '0;
    end else if (cmd_i.find && hit && hit_black) begin
      top_cur_q <= w_next;
    end else if (push) begin
      top_v_q   <= w_idx;
      top_cur_q <= '0;
    end else if (cmd_i.pop_load) begin
      top_v_q   <= stk_rd_q.vidx;
      top_cur_q <= stk_rd_q.cur;
    end
  end

  // Marks, depth and cycle flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_q   <= '0;
      black_q  <= '0;
      depth_q  <= '0;
      result_q <= 1'b0;
    end else if (cmd_i.load_start) begin
      gray_q   <= MAX_NODES'(1) << from_idx;
      black_q  <= '0;
      depth_q  <= CUR_W'(1);
      result_q <= 1'b0;
    end else if (cmd_i.find) begin
      if (!hit) begin
        black_q[top_v_q] <= 1'b1;
        gray_q[top_v_q]  <= 1'b0;
        depth_q          <= depth_q - CUR_W'(1);
      end else if (hit_gray) begin
        result_q <= 1'b1;
        depth_q  <= '0;
      end else if (push) begin
        gray_q[w_idx] <= 1'b1;
        depth_q       <= depth_q + CUR_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      out_flag_q <= result_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_flag_o  = out_flag_q;

  assign status_o.start_ok  = start_ok;
  assign status_o.add_ok    = add_ok;
  assign status_o.hit       = hit;
  assign status_o.hit_gray  = hit_gray;
  assign status_o.depth_one = depth_one;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### hdl/dcd_checker.sv
// Port-level checks for directed_cycle_detect, bound to the top level.
// Depends on dcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dcd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [dcd_pkg::MODE_W-1:0]     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [dcd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import dcd_pkg::*;

  logic in_beat, check_beat, clear_beat, out_stall, pad_zero;

  // Decode the handshakes seen on the ports
  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign check_beat = in_beat && (s_axis_tuser == MODE_CHECK);
  assign clear_beat = in_beat && (s_axis_tuser == MODE_CLEAR);
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign pad_zero   = (m_axis_tdata[OUT_DATA_W-1:1] == '0);

  // A stalled result beat stays valid
  `ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, out_stall, m_axis_tvalid, "result beat dropped")

  // A stalled result beat holds its flag
  `ASSERT_NEXT(a_data_hold, clk_i, rst_ni, out_stall, $stable(m_axis_tdata), "result data moved")

  // Only the flag bit of the result is ever set
  `ASSERT_IMPL(a_out_pad, clk_i, rst_ni, m_axis_tvalid, pad_zero, "result padding not zero")

  // An accepted check keeps the input side busy on the following cycle
  `ASSERT_NEXT(a_check_busy, clk_i, rst_ni, check_beat, !s_axis_tready, "ready after check")

  // A clear finishes in the cycle it is taken
  `ASSERT_NEXT(a_clear_fast, clk_i, rst_ni, clear_beat, s_axis_tready, "busy after clear")

endmodule

bind directed_cycle_detect dcd_checker u_dcd_checker (.*);
